// ===== hdl/sls_pkg.sv =====
// stereo loop slicer package
// shared constants, register and item kind codes; no dependencies
package sls_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int RAND_W       = 16;
    localparam int RECORD_MAX_W = 13;
    localparam int REPEAT_W     = 8;
    localparam int LEVEL_W      = 16;
    localparam int LEVEL_FRAC   = 15;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int KIND_W       = 2;

    localparam int RECORD_MAX_RST = 4096;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX_RST = REPEAT_W'(4);
    localparam logic [LEVEL_W-1:0]  LEVEL_RST      = LEVEL_W'(32768);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RECORD_MAX = 2'd0,
        REG_REPEAT_MAX = 2'd1,
        REG_TRIG_MODE  = 2'd2,
        REG_LEVEL      = 2'd3
    } t_cfg_reg;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_TRIG_ON  = 2'd1,
        KIND_TRIG_OFF = 2'd2
    } t_kind;

endpackage

// ===== hdl/sls_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module sls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/stereo_loop_slicer_unit.sv =====
// stereo loop slicer top level: control state, store ram and output scaling
// depends on sls_pkg and sls_ram
//
// usage:
// input channel i_in_valid / o_in_stall carries one item per transfer: a stereo
// sample (kind sample) or a trigger on / trigger off event. every sample gives
// exactly one output transfer on o_out_valid / i_out_stall; triggers give none.
// while recording, samples are written to the store and passed through; once a
// slice is complete it is played back in a loop, scaled by the level register.
// one item per clock is taken while o_in_stall is low. a sample reaches the output
// through the read stage and the output register: the store read is registered at
// its input transfer, and the scaled value is then loaded into the output register once it is free.
// store write, store read and all index updates are done in the cycle of the
// input transfer, which sets the rate of one item per cycle while not stalled.
// when the receiver stalls, the output register and the read stage hold; the
// input stalls only once both are full.
// configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data while
// the block is idle. reset clears control state and loads register defaults;
// the store needs no clearing, it is only read where it has been written.
module stereo_loop_slicer_unit
    import sls_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [KIND_W-1:0]             i_kind,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    input  logic [RAND_W-1:0]             i_rand_length,
    input  logic [RAND_W-1:0]             i_rand_repeats,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int MAXV_W  = (CNT_W > RECORD_MAX_W) ? CNT_W : RECORD_MAX_W;
    localparam int WORD_W  = 2 * SAMPLE_BITS;
    localparam int PROD_W  = SAMPLE_BITS + LEVEL_W + 1;
    localparam int RMAX_INIT = (RECORD_MAX_RST > STORE_DEPTH) ? STORE_DEPTH : RECORD_MAX_RST;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    // configuration registers
    logic [CNT_W-1:0]    r_record_max;
    logic [REPEAT_W-1:0] r_repeat_max;
    logic                r_trig_mode;
    logic [LEVEL_W-1:0]  r_level;
    logic [MAXV_W-1:0]   cfg_rmax_ext;

    // control state
    logic                r_recording,     n_recording;
    logic [CNT_W-1:0]    r_write_index,   n_write_index;
    logic [CNT_W-1:0]    r_slice_length,  n_slice_length;
    logic [CNT_W-1:0]    r_read_index,    n_read_index;
    logic [ADDR_W-1:0]   r_loop_end,      n_loop_end;
    logic [REPEAT_W-1:0] r_repeats_done,  n_repeats_done;
    logic [REPEAT_W-1:0] r_repeat_target, n_repeat_target;
    logic                r_first_draw,    n_first_draw;

    // pipeline
    logic                r_s1_valid;
    logic                r_s1_fwd;
    logic [WORD_W-1:0]   r_s1_fwd_data;
    logic                r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    logic                in_xfer;
    logic                out_free;
    logic                out_load;

    logic [RAND_W+CNT_W-1:0]    len_prod;
    logic [RAND_W+REPEAT_W-1:0] rep_prod;
    logic [CNT_W-1:0]           draw_len;
    logic [REPEAT_W-1:0]        draw_rep;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   s1_word;

    logic signed [SAMPLE_BITS-1:0] s1_left;
    logic signed [SAMPLE_BITS-1:0] s1_right;
    logic signed [PROD_W-1:0]      prod_left;
    logic signed [PROD_W-1:0]      prod_right;
    logic signed [PROD_W-1:0]      level_ext;

    function automatic logic [SAMPLE_BITS-1:0] f_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = p >>> LEVEL_FRAC;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // random draws: 1 + ((rand * max) >> 16)
    assign len_prod = {{CNT_W{1'b0}}, i_rand_length} * {{RAND_W{1'b0}}, r_record_max};
    assign rep_prod = {{REPEAT_W{1'b0}}, i_rand_repeats} * {{RAND_W{1'b0}}, r_repeat_max};
    assign draw_len = len_prod[RAND_W +: CNT_W] + CNT_W'(1);
    assign draw_rep = rep_prod[RAND_W +: REPEAT_W] + REPEAT_W'(1);

    assign wr_data = {i_left_in, i_right_in};
    assign wr_addr = r_write_index[ADDR_W-1:0];

    always_comb begin
        n_recording     = r_recording;
        n_write_index   = r_write_index;
        n_slice_length  = r_slice_length;
        n_read_index    = r_read_index;
        n_loop_end      = r_loop_end;
        n_repeats_done  = r_repeats_done;
        n_repeat_target = r_repeat_target;
        n_first_draw    = r_first_draw;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        if (in_xfer) begin
            unique case (t_kind'(i_kind))
                KIND_SAMPLE: begin
                    if (r_first_draw) begin
                        n_slice_length  = draw_len;
                        n_repeat_target = draw_rep;
                        n_first_draw    = 1'b0;
                    end
                    if (r_recording) begin
                        wr_en         = r_write_index < DEPTH_CNT;
                        n_write_index = r_write_index + CNT_W'(1);
                        if (n_write_index >= n_slice_length || n_write_index >= DEPTH_CNT) begin
                            n_recording  = 1'b0;
                            n_loop_end   = r_write_index[ADDR_W-1:0];
                            n_read_index = '0;
                            if (!r_trig_mode) begin
                                n_repeat_target = draw_rep;
                                n_repeats_done  = '0;
                            end
                        end
                    end
                    rd_en   = 1'b1;
                    rd_addr = (n_read_index < DEPTH_CNT) ? n_read_index[ADDR_W-1:0] : '0;
                    n_read_index = n_read_index + CNT_W'(1);
                    if (!n_recording && n_read_index > CNT_W'(n_loop_end)) begin
                        n_read_index = '0;
                        if (!r_trig_mode) begin
                            n_repeats_done = n_repeats_done + REPEAT_W'(1);
                            if (n_repeats_done >= n_repeat_target) begin
                                n_repeat_target = draw_rep;
                                n_repeats_done  = '0;
                                n_slice_length  = draw_len;
                                n_write_index   = '0;
                                n_recording     = 1'b1;
                            end
                        end
                    end
                end
                KIND_TRIG_ON: begin
                    if (r_trig_mode) begin
                        n_slice_length = DEPTH_CNT;
                        n_write_index  = '0;
                        n_recording    = 1'b1;
                        n_read_index   = '0;
                        n_first_draw   = 1'b0;
                    end
                end
                KIND_TRIG_OFF: begin
                    if (r_trig_mode) begin
                        n_recording  = 1'b0;
                        n_loop_end   = (r_write_index == '0) ? '0
                                     : ADDR_W'(r_write_index - CNT_W'(1));
                        n_read_index = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    sls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cfg_rmax_ext = MAXV_W'(i_cfg_data[RECORD_MAX_W-1:0]);

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_max    <= CNT_W'(RMAX_INIT);
            r_repeat_max    <= REPEAT_MAX_RST;
            r_trig_mode     <= 1'b0;
            r_level         <= LEVEL_RST;
            r_recording     <= 1'b1;
            r_write_index   <= '0;
            r_slice_length  <= '0;
            r_read_index    <= '0;
            r_loop_end      <= ADDR_W'(1);
            r_repeats_done  <= '0;
            r_repeat_target <= REPEAT_W'(1);
            r_first_draw    <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_RECORD_MAX: begin
                        r_record_max <= (cfg_rmax_ext > MAXV_W'(STORE_DEPTH)) ? DEPTH_CNT
                                      : CNT_W'(cfg_rmax_ext);
                    end
                    REG_REPEAT_MAX: r_repeat_max <= i_cfg_data[REPEAT_W-1:0];
                    REG_TRIG_MODE:  r_trig_mode  <= i_cfg_data[0];
                    REG_LEVEL:      r_level      <= i_cfg_data[LEVEL_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_recording     <= n_recording;
            r_write_index   <= n_write_index;
            r_slice_length  <= n_slice_length;
            r_read_index    <= n_read_index;
            r_loop_end      <= n_loop_end;
            r_repeats_done  <= n_repeats_done;
            r_repeat_target <= n_repeat_target;
            r_first_draw    <= n_first_draw;
        end
    end

    // read stage, forwards a same-cycle write to the read address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rd_en) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_fwd      <= wr_en && (wr_addr == rd_addr);
            r_s1_fwd_data <= wr_data;
        end
    end

    assign s1_word   = r_s1_fwd ? r_s1_fwd_data : rd_data;
    assign s1_left   = s1_word[WORD_W-1:SAMPLE_BITS];
    assign s1_right  = s1_word[SAMPLE_BITS-1:0];
    assign level_ext = PROD_W'($signed({1'b0, r_level}));
    assign prod_left  = PROD_W'(s1_left) * level_ext;
    assign prod_right = PROD_W'(s1_right) * level_ext;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_left_out  <= f_sat(prod_left);
            r_right_out <= f_sat(prod_right);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    a_rec_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recording |-> (r_write_index < DEPTH_CNT))
        else $error("write index beyond store while recording");

    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_recording |-> (r_read_index <= CNT_W'(r_loop_end)))
        else $error("read index past loop end");

    a_repeat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_repeats_done < r_repeat_target)
        else $error("repeat count reached target without a new slice");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free pipeline slot");

endmodule
